// ----- sv/cth_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cth_pkg: shared constants and types of the crypt table string hash
// Seed values, table geometry and generator constants used by the table
// builder and the hash datapath.
// ----------------------------------------------------------------------------
package cth_pkg;

  // table geometry: five slices of 256 words
  localparam int unsigned SLICE_WORDS = 256;
  localparam int unsigned SLICE_COUNT = 5;
  localparam int unsigned TABLE_WORDS = SLICE_WORDS * SLICE_COUNT;
  localparam int unsigned COL_W       = $clog2(SLICE_WORDS);
  localparam int unsigned SLICE_W     = $clog2(SLICE_COUNT);
  localparam int unsigned ADDR_W      = $clog2(TABLE_WORDS);

  // seeds after reset and after every terminator
  localparam logic [31:0] SEED_ONE_INIT = 32'h7FED_7FED;
  localparam logic [31:0] SEED_TWO_INIT = 32'hEEEE_EEEE;

  // table generator: seed = (seed * 125 + 3) mod 0x2AAAAB
  localparam logic [21:0] GEN_START = 22'h10_0001;
  localparam logic [23:0] GEN_MOD   = 24'h2A_AAAB;
  localparam logic [6:0]  GEN_MUL   = 7'd125;
  localparam logic [1:0]  GEN_ADD   = 2'd3;

  // configuration
  localparam int unsigned     KIND_W          = 3;
  localparam logic [KIND_W-1:0] HASH_KIND_RESET = 3'd2;

  // result fields
  localparam int unsigned HASH_W       = 32;
  localparam int unsigned BUCKET_W     = 10;
  localparam int unsigned BUCKET_COUNT = 1024;

  // table read request from the hash datapath
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

endpackage

// ----- sv/cth_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cth_table: crypt table memory with its fill sequencer
// Builds the 1280-word table once after reset from the seed recurrence, then
// serves one registered read per cycle.
// ----------------------------------------------------------------------------
module cth_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cth_pkg::tbl_rd_t              rd_req,
  output logic [31:0]                   rd_data,
  output logic                          tbl_ready
);

  typedef enum logic [1:0] {
    ST_MUL,
    ST_RED,
    ST_DONE
  } gen_state_t;

  gen_state_t                     state_r;
  logic [21:0]                    gen_s_r;
  logic [23:0]                    gen_x_r;
  logic                           half_r;
  logic [15:0]                    hi_r;
  logic [cth_pkg::COL_W-1:0]      col_r;
  logic [cth_pkg::SLICE_W-1:0]    sl_r;
  logic                           ready_r;

  logic [31:0] mem [cth_pkg::TABLE_WORDS];
  logic [31:0] rd_data_r;

  logic [28:0] gen_t;
  logic [23:0] gen_x_nxt;
  logic [21:0] gen_s_nxt;
  logic        wr_en;
  logic [cth_pkg::ADDR_W-1:0] wr_addr;
  logic [31:0] wr_data;
  logic        last_word;

  // step, first half: t = s*125 + 3, then fold 2^23 == -1 (mod M) since 3M = 2^23 + 1
  always_comb begin
    gen_t     = 29'(gen_s_r) * 29'(cth_pkg::GEN_MUL) + 29'(cth_pkg::GEN_ADD);
    gen_x_nxt = 24'(gen_t[22:0]) + cth_pkg::GEN_MOD - 24'(gen_t[28:23]);
  end

  // step, second half: x is below 4M, subtract the right multiple of M
  always_comb begin
    priority if (gen_x_r >= 24'(3 * cth_pkg::GEN_MOD)) begin
      gen_s_nxt = 22'(gen_x_r - 24'(3 * cth_pkg::GEN_MOD));
    end else if (gen_x_r >= 24'(2 * cth_pkg::GEN_MOD)) begin
      gen_s_nxt = 22'(gen_x_r - 24'(2 * cth_pkg::GEN_MOD));
    end else if (gen_x_r >= cth_pkg::GEN_MOD) begin
      gen_s_nxt = 22'(gen_x_r - cth_pkg::GEN_MOD);
    end else begin
      gen_s_nxt = gen_x_r[21:0];
    end
  end

  // word address is slice*256 + column
  assign wr_addr   = {sl_r, col_r};
  assign wr_data   = {hi_r, gen_s_nxt[15:0]};
  assign wr_en     = (state_r == ST_RED) && half_r;
  assign last_word = (sl_r == cth_pkg::SLICE_W'(cth_pkg::SLICE_COUNT - 1)) &&
                     (col_r == cth_pkg::COL_W'(cth_pkg::SLICE_WORDS - 1));

  // fill sequencer: two recurrence steps per word, high half first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MUL;
      gen_s_r <= cth_pkg::GEN_START;
      half_r  <= 1'b0;
      col_r   <= '0;
      sl_r    <= '0;
      ready_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_MUL: begin
          gen_x_r <= gen_x_nxt;
          state_r <= ST_RED;
        end
        ST_RED: begin
          gen_s_r <= gen_s_nxt;
          if (!half_r) begin
            hi_r    <= gen_s_nxt[15:0];
            half_r  <= 1'b1;
            state_r <= ST_MUL;
          end else begin
            half_r <= 1'b0;
            if (last_word) begin
              state_r <= ST_DONE;
              ready_r <= 1'b1;
            end else begin
              state_r <= ST_MUL;
              if (sl_r == cth_pkg::SLICE_W'(cth_pkg::SLICE_COUNT - 1)) begin
                sl_r  <= '0;
                col_r <= col_r + 1'b1;
              end else begin
                sl_r <= sl_r + 1'b1;
              end
            end
          end
        end
        ST_DONE: begin
          ready_r <= 1'b1;
        end
        default: begin
          state_r <= ST_DONE;
        end
      endcase
    end
  end

  // table memory: one write port for the fill, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign tbl_ready = ready_r;

endmodule

// ----- sv/cth_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cth_mod: pipelined bucket remainder
// Restoring remainder of the hash by the bucket count, four dividend bits
// per stage; the last stage doubles as the result register.
// ----------------------------------------------------------------------------
module cth_mod #(
  parameter int unsigned BUCKET_COUNT = cth_pkg::BUCKET_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [cth_pkg::HASH_W-1:0]    in_hash,
  output logic                          res_vld,
  output logic [cth_pkg::HASH_W-1:0]    res_hash,
  output logic [cth_pkg::BUCKET_W-1:0]  res_bucket
);

  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned STAGES         = cth_pkg::HASH_W / BITS_PER_STAGE;
  localparam int unsigned RW             = $clog2(BUCKET_COUNT) + 1;
  localparam logic [RW-1:0] DIVISOR      = RW'(BUCKET_COUNT);

  logic                       vld_r  [STAGES];
  logic [cth_pkg::HASH_W-1:0] hash_r [STAGES];
  logic [RW-1:0]              rem_r  [STAGES];

  // shift in four bits, subtracting the divisor after each
  function automatic logic [RW-1:0] rem_step(input logic [RW-1:0] rem_in,
                                             input logic [BITS_PER_STAGE-1:0] nib);
    logic [RW-1:0] r;
    r = rem_in;
    for (int i = BITS_PER_STAGE - 1; i >= 0; i--) begin
      r = RW'({r, nib[i]});
      if (r >= DIVISOR) begin
        r = r - DIVISOR;
      end
    end
    return r;
  endfunction

  // advance all stages together, hold while the result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0]  <= in_vld;
      hash_r[0] <= in_hash;
      rem_r[0]  <= rem_step('0, in_hash[cth_pkg::HASH_W-1 -: BITS_PER_STAGE]);
      for (int k = 1; k < STAGES; k++) begin
        vld_r[k]  <= vld_r[k-1];
        hash_r[k] <= hash_r[k-1];
        rem_r[k]  <= rem_step(rem_r[k-1],
                              hash_r[k-1][cth_pkg::HASH_W-1-BITS_PER_STAGE*k -: BITS_PER_STAGE]);
      end
    end
  end

  assign res_vld    = vld_r[STAGES-1];
  assign res_hash   = hash_r[STAGES-1];
  assign res_bucket = cth_pkg::BUCKET_W'(rem_r[STAGES-1]);

endmodule

// ----- sv/crypt_table_string_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crypt_table_string_hash: one-way string hash over a crypt table
// Folds key bytes to upper case, mixes them into two seeds through a
// 1280-word table and emits hash and bucket index on each zero byte.
// ----------------------------------------------------------------------------
//  channel  dir  ports                                  request
//  in       in   in_valid in_ready in_key_byte          one key byte
//  out      out  out_valid out_ready out_hash_value     one hash result
//                out_bucket_index
//  cfg      in   cfg_we cfg_wdata                       hash_kind write
//
// One key byte is accepted every cycle while in_ready is high: the read is
// registered, the seed update follows, and the table address needs no seed.
// A zero byte's result passes the seed stage and then the eight remainder
// stages, four bits each, on its way to the output.
// After reset the table fill runs two generator steps per word, each a
// multiply and a reduce state; in_ready stays low until it is done.
// A stalled result holds the remainder pipeline; a zero byte waiting behind
// it holds the input.
// ----------------------------------------------------------------------------
module crypt_table_string_hash #(
  parameter int unsigned BUCKET_COUNT = cth_pkg::BUCKET_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_key_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cth_pkg::HASH_W-1:0]        out_hash_value,
  output logic [cth_pkg::BUCKET_W-1:0]      out_bucket_index,
  input  logic                              cfg_we,
  input  logic [cth_pkg::KIND_W-1:0]        cfg_wdata
);

  logic [cth_pkg::KIND_W-1:0]  hash_kind_r;
  logic [31:0]                 seed_one_r;
  logic [31:0]                 seed_two_r;
  logic                        s1_vld_r;
  logic [7:0]                  s1_ch_r;

  cth_pkg::tbl_rd_t            rd_req;
  logic [31:0]                 rd_word;
  logic                        tbl_ready;
  logic                        pipe_en;
  logic                        s1_term;
  logic                        s1_go;
  logic                        in_acc;
  logic [7:0]                  ch_up;
  logic [cth_pkg::SLICE_W-1:0] slice;
  logic [31:0]                 seed_one_nxt;
  logic [31:0]                 seed_two_nxt;

  // fold a-z to upper case
  always_comb begin
    if (in_key_byte >= 8'h61 && in_key_byte <= 8'h7A) begin
      ch_up = in_key_byte - 8'h20;
    end else begin
      ch_up = in_key_byte;
    end
  end

  // clamp the slice selector to the last slice
  always_comb begin
    if (hash_kind_r > cth_pkg::KIND_W'(cth_pkg::SLICE_COUNT - 1)) begin
      slice = cth_pkg::SLICE_W'(cth_pkg::SLICE_COUNT - 1);
    end else begin
      slice = cth_pkg::SLICE_W'(hash_kind_r);
    end
  end

  // handshake: a terminator moves on only when the remainder pipe moves
  assign pipe_en  = !out_valid || out_ready;
  assign s1_term  = (s1_ch_r == 8'h00);
  assign s1_go    = !s1_term || pipe_en;
  assign in_ready = tbl_ready && (!s1_vld_r || s1_go);
  assign in_acc   = in_valid && in_ready;

  assign rd_req.en   = in_acc;
  assign rd_req.addr = {slice, ch_up};

  // seed mix with the table word read for this byte
  always_comb begin
    seed_one_nxt = rd_word ^ (seed_one_r + seed_two_r);
    seed_two_nxt = 32'(s1_ch_r) + seed_one_nxt + seed_two_r + (seed_two_r << 5) + 32'd3;
  end

  // hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_kind_r <= cth_pkg::HASH_KIND_RESET;
    end else if (cfg_we) begin
      hash_kind_r <= cfg_wdata;
    end
  end

  // seed stage: update or restart the seeds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      seed_one_r <= cth_pkg::SEED_ONE_INIT;
      seed_two_r <= cth_pkg::SEED_TWO_INIT;
    end else begin
      if (s1_vld_r && s1_go) begin
        if (s1_term) begin
          seed_one_r <= cth_pkg::SEED_ONE_INIT;
          seed_two_r <= cth_pkg::SEED_TWO_INIT;
        end else begin
          seed_one_r <= seed_one_nxt;
          seed_two_r <= seed_two_nxt;
        end
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
        s1_ch_r  <= ch_up;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  cth_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_req    (rd_req),
    .rd_data   (rd_word),
    .tbl_ready (tbl_ready)
  );

  cth_mod #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .in_vld     (s1_vld_r && s1_term),
    .in_hash    (seed_one_r),
    .res_vld    (out_valid),
    .res_hash   (out_hash_value),
    .res_bucket (out_bucket_index)
  );

endmodule
